/* src/pdp_pkg.sv */
// Shared types, codes and widths of the pixel density projection block.
package pdp_pkg;

  localparam int CFG_W  = 11;
  localparam int CFG_IW = 2;
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int ROW_W  = 11;
  localparam int QUAD_W = 21;
  localparam int VAL_W  = 21;
  localparam int NQUAD  = 4;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

  localparam logic [PIX_W-1:0] LIT_MASK = 8'hf8;

  // Result queue depth, counted in result groups.
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_PIXEL = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROW  = 2'd0;
  localparam kind_t KIND_QUAD = 2'd1;
  localparam kind_t KIND_COL  = 2'd2;

  typedef logic [CFG_IW-1:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam reg_idx_t REG_FRAME_HEIGHT = 2'd1;
  localparam reg_idx_t REG_CENTER_X     = 2'd2;
  localparam reg_idx_t REG_CENTER_Y     = 2'd3;

  // Kind of result group held in one queue entry.
  typedef enum logic [1:0] {
    GRP_COL,
    GRP_ROW,
    GRP_FRAME
  } grp_e;

  typedef struct packed {
    grp_e                         grp;
    logic [IDX_W-1:0]             index;
    logic [VAL_W-1:0]             value;
    logic [NQUAD-1:0][QUAD_W-1:0] quads;
  } res_grp_t;

  // Request to the column store, issued in the cycle an item is accepted.
  typedef struct packed {
    logic rd_en;
    logic inc;
    logic clear;
  } col_ctl_t;

endpackage

/* src/pixel_density_projection.sv */
// A result goes via the read stage and output queue to the master side. Throughput:
// one input item per cycle while s_tready is high; results leave at one per cycle
// while m_tready is high, and a frame end issues five transfers. Up to four result
// groups wait in the output queue. The column store is read at accept and written
// back in the next cycle (forwarded). After reset and each start-frame command
// the store is swept to zero with s_tready low; config writes are taken throughout.
module pixel_density_projection #(
  parameter int MAX_WIDTH  = pdp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pdp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // pixel[7:0], column_index[17:8]
  input  logic [1:0]                  s_tuser,   // cmd[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // index[9:0], value[30:10]
  output logic [1:0]                  m_tuser,   // kind[1:0]
  output logic                        m_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pdp_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [pdp_pkg::CFG_W-1:0]   cfg_data_i
);
  import pdp_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int DXW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int DYW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  logic [CFG_W-1:0]  width_q, height_q, center_x_q, center_y_q;
  logic [XW-1:0]     cursor_x_q;
  logic [YW-1:0]     cursor_y_q;
  logic [ROW_W-1:0]  row_q;
  logic [NQUAD-1:0][QUAD_W-1:0] quad_q, quad_new;

  cmd_t              cmd;
  logic [PIX_W-1:0]  pixel;
  logic [IDX_W-1:0]  column_index;
  logic              acc, lit, row_end, last_row, in_range;
  logic [DXW-1:0]    eff_w;
  logic [DYW-1:0]    eff_h;
  logic [1:0]        quad;
  logic [ROW_W-1:0]  row_new;

  logic              b_valid_q, b_oor_q;
  logic              b_valid_d;
  grp_e              b_grp_q;
  logic [IDX_W-1:0]  b_idx_q;
  logic [ROW_W-1:0]  b_row_q;
  logic [NQUAD-1:0][QUAD_W-1:0] b_quads_q;

  col_ctl_t          col_ctl;
  logic [XW-1:0]     col_addr;
  logic              col_busy;
  logic [CNT_W-1:0]  col_data;
  res_grp_t          grp;
  logic [QCW-1:0]    q_cnt;
  logic [IDX_W-1:0]  out_index;
  logic [VAL_W-1:0]  out_value;

  assign cmd          = s_tuser;
  assign pixel        = s_tdata[7:0];
  assign column_index = s_tdata[17:8];
  assign cfg_ready_o  = 1'b1;

  // Room is reserved for the item in the read stage and the one being accepted.
  assign s_tready = !col_busy &&
                    (({1'b0, q_cnt} + (QCW+1)'(b_valid_q) + (QCW+1)'(1)) <=
                     (QCW+1)'(QDEPTH));
  assign acc = s_tvalid && s_tready;

  always_comb begin
    if (width_q == '0) begin
      eff_w = DXW'(1);
    end else if (DXW'(width_q) > DXW'(MAX_WIDTH)) begin
      eff_w = DXW'(MAX_WIDTH);
    end else begin
      eff_w = DXW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = DYW'(1);
    end else if (DYW'(height_q) > DYW'(MAX_HEIGHT)) begin
      eff_h = DYW'(MAX_HEIGHT);
    end else begin
      eff_h = DYW'(height_q);
    end
  end

  assign lit       = |(pixel & LIT_MASK);
  assign row_end   = (DXW'(cursor_x_q) + DXW'(1)) >= eff_w;
  assign last_row  = (DYW'(cursor_y_q) + DYW'(1)) >= eff_h;
  assign quad      = {DYW'(cursor_y_q) >= DYW'(center_y_q),
                      DXW'(cursor_x_q) >= DXW'(center_x_q)};
  assign row_new   = (lit && row_q != '1) ? row_q + ROW_W'(1) : row_q;
  assign in_range  = 32'(column_index) < 32'(MAX_WIDTH);
  assign b_valid_d = acc && ((cmd == CMD_PIXEL && row_end) || cmd == CMD_READ);

  always_comb begin
    for (int i = 0; i < NQUAD; i++) begin
      quad_new[i] = quad_q[i];
      if (lit && quad == 2'(i) && quad_q[i] != '1) begin
        quad_new[i] = quad_q[i] + QUAD_W'(1);
      end
    end
  end

  always_comb begin
    col_ctl  = '0;
    col_addr = cursor_x_q;
    case (cmd)
      CMD_PIXEL: begin
        col_ctl.rd_en = acc;
        col_ctl.inc   = lit;
      end
      CMD_READ: begin
        col_ctl.rd_en = acc && in_range;
        col_addr      = XW'(column_index);
      end
      CMD_CLEAR: begin
        col_ctl.clear = acc;
      end
      default: begin
        col_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q    <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q   <= cfg_data_i;
        REG_CENTER_X:     center_x_q <= cfg_data_i;
        REG_CENTER_Y:     center_y_q <= cfg_data_i;
        default:          width_q    <= width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      row_q      <= '0;
      quad_q     <= '0;
      b_valid_q  <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (acc) begin
        case (cmd)
          CMD_PIXEL: begin
            quad_q <= quad_new;
            if (row_end) begin
              row_q      <= '0;
              cursor_x_q <= '0;
              cursor_y_q <= last_row ? '0 : cursor_y_q + YW'(1);
            end else begin
              row_q      <= row_new;
              cursor_x_q <= cursor_x_q + XW'(1);
            end
          end
          CMD_CLEAR: begin
            cursor_x_q <= '0;
            cursor_y_q <= '0;
            row_q      <= '0;
            quad_q     <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Read-stage payload; only meaningful while b_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_quads_q <= quad_new;
      b_row_q   <= row_new;
      b_oor_q   <= !in_range;
      if (cmd == CMD_READ) begin
        b_grp_q <= GRP_COL;
        b_idx_q <= column_index;
      end else begin
        b_grp_q <= last_row ? GRP_FRAME : GRP_ROW;
        b_idx_q <= IDX_W'(cursor_y_q);
      end
    end
  end

  always_comb begin
    grp.grp   = b_grp_q;
    grp.index = b_idx_q;
    grp.quads = b_quads_q;
    if (b_grp_q == GRP_COL) begin
      grp.value = b_oor_q ? '0 : VAL_W'(col_data);
    end else begin
      grp.value = VAL_W'(b_row_q);
    end
  end

  pdp_col_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_col_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (col_ctl),
    .addr_i    (col_addr),
    .busy_o    (col_busy),
    .rd_data_o (col_data)
  );

  pdp_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid_q),
    .grp_i   (grp),
    .cnt_o   (q_cnt),
    .valid_o (m_tvalid),
    .ready_i (m_tready),
    .kind_o  (m_tuser),
    .index_o (out_index),
    .value_o (out_value),
    .last_o  (m_tlast)
  );

  assign m_tdata = {1'b0, out_value, out_index};

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd == CMD_CLEAR) |=> !s_tready)
    else $error("input accepted right after a start-frame command");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (q_cnt < QCW'(QDEPTH)))
    else $error("result group arrives at a full queue");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd == CMD_PIXEL && row_end) |=> (cursor_x_q == '0 && row_q == '0))
    else $error("row end did not reset column cursor and row count");

endmodule

/* src/pdp_col_store.sv */
// Column count memory with read-modify-write increment and clearing sweep.
module pdp_col_store #(
  parameter int MAX_WIDTH = pdp_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdp_pkg::col_ctl_t             ctl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  output logic                          busy_o,
  output logic [pdp_pkg::CNT_W-1:0]     rd_data_o
);
  import pdp_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [CNT_W-1:0] mem [MAX_WIDTH];
  logic [CNT_W-1:0] rd_q;
  logic [CNT_W-1:0] fwd_data_q;
  logic             fwd_hit_q;
  logic             b_inc_q;
  logic [AW-1:0]    b_addr_q;
  logic             clr_q;
  logic [AW-1:0]    clr_addr_q;
  logic [CNT_W-1:0] wr_data;

  // The entry written this cycle may be the one the next item just read.
  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;
  assign wr_data   = (rd_data_o == '1) ? rd_data_o : rd_data_o + CNT_W'(1);
  assign busy_o    = clr_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (b_inc_q) begin
      mem[b_addr_q] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[addr_i];
    end
    fwd_data_q <= wr_data;
    b_addr_q   <= addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      b_inc_q    <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      b_inc_q   <= ctl_i.rd_en && ctl_i.inc;
      fwd_hit_q <= b_inc_q && (b_addr_q == addr_i);
      if (ctl_i.clear) begin
        clr_q      <= 1'b1;
        clr_addr_q <= '0;
      end else if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  a_no_inc_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_q && b_inc_q))
    else $error("column increment during clearing sweep");

  a_no_read_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_q && ctl_i.rd_en))
    else $error("column read issued during clearing sweep");

  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (clr_q && clr_addr_q == '0))
    else $error("clear request did not start a sweep");

endmodule

/* src/pdp_res_queue.sv */
// Queue of result groups that issues one result per output transfer.
module pdp_res_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  pdp_pkg::res_grp_t             grp_i,
  output logic [pdp_pkg::QCW-1:0]       cnt_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output pdp_pkg::kind_t                kind_o,
  output logic [pdp_pkg::IDX_W-1:0]     index_o,
  output logic [pdp_pkg::VAL_W-1:0]     value_o,
  output logic                          last_o
);
  import pdp_pkg::*;

  localparam logic [2:0] BEAT_LAST = 3'd4;

  res_grp_t         ent_q [QDEPTH];
  logic [QPW-1:0]   wr_ptr_q;
  logic [QPW-1:0]   rd_ptr_q;
  logic [QCW-1:0]   cnt_q;
  logic [2:0]       beat_q;
  res_grp_t         head;
  logic [1:0]       qsel;
  logic             xfer;
  logic             pop;

  assign head    = ent_q[rd_ptr_q];
  assign qsel    = 2'(beat_q - 3'd1);
  assign valid_o = (cnt_q != '0);
  assign cnt_o   = cnt_q;
  assign xfer    = valid_o && ready_i;
  assign pop     = xfer && last_o;

  always_comb begin
    kind_o  = KIND_COL;
    index_o = head.index;
    value_o = head.value;
    last_o  = 1'b1;
    case (head.grp)
      GRP_COL: begin
        kind_o = KIND_COL;
      end
      GRP_ROW: begin
        kind_o = KIND_ROW;
      end
      GRP_FRAME: begin
        if (beat_q == '0) begin
          kind_o = KIND_ROW;
          last_o = 1'b0;
        end else begin
          kind_o  = KIND_QUAD;
          index_o = IDX_W'(qsel);
          value_o = head.quads[qsel];
          last_o  = (beat_q == BEAT_LAST);
        end
      end
      default: begin
        kind_o = KIND_COL;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      beat_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPW'(1);
        beat_q   <= '0;
      end else if (xfer) begin
        beat_q <= beat_q + 3'd1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + QCW'(1);
        2'b01:   cnt_q <= cnt_q - QCW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && cnt_q == QCW'(QDEPTH)))
    else $error("result group pushed into a full queue");

  a_beat_only_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != '0) |-> (valid_o && head.grp == GRP_FRAME))
    else $error("beat counter advanced on a single-result group");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

/* sim/pixel_density_projection_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench that predicts row, quadrant and column counts on the result stream.
module pixel_density_projection_tb;
  import pdp_pkg::*;

  localparam cmd_t CMD_UNUSED      = 2'd3;
  localparam int   WATCHDOG_LIMIT  = 8000;
  localparam int   SETTLE_CYCLES   = 8;
  localparam int   HOLD_OFF_CYCLES = 300;
  localparam int   RANDOM_ITEMS    = 190;
  localparam int   MAX_REPORTS     = 20;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } count_result_t;

  // Keeps its own copy of the projection state and the counts it is expected to emit.
  class projection_scoreboard;
    count_result_t     expected_counts[$];
    logic [CFG_W-1:0]  width_reg, height_reg, center_x_reg, center_y_reg;
    logic [CNT_W-1:0]  column_count[DEF_MAX_WIDTH];
    logic [QUAD_W-1:0] quad_total[NQUAD];
    logic [ROW_W-1:0]  row_count;
    int unsigned       cur_x, cur_y;
    int                errors, results_seen, frames_seen;

    function new();
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      center_x_reg = '0;
      center_y_reg = '0;
      errors       = 0;
      results_seen = 0;
      frames_seen  = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (column_count[i]) column_count[i] = '0;
      foreach (quad_total[i]) quad_total[i] = '0;
      row_count = '0;
      cur_x     = 0;
      cur_y     = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        REG_CENTER_X:     center_x_reg = data;
        REG_CENTER_Y:     center_y_reg = data;
        default: ;
      endcase
    endfunction

    // A zero size counts as one; sizes above the store are clamped.
    function int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned limit);
      if (v == '0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function void add_count(kind_t kd, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                            logic tail);
      expected_counts.push_back({kd, idx, val, tail});
    endfunction

    function string describe(count_result_t r);
      return $sformatf("kind %0d index %0d value %0d last %0d",
                       r.kind, r.index, r.value, r.last);
    endfunction

    function void take_input(cmd_t cmd, logic [PIX_W-1:0] pix, logic [IDX_W-1:0] col);
      int unsigned w, h, q;
      bit          last_row;
      case (cmd)
        CMD_CLEAR: clear_counts();
        CMD_READ:  add_count(KIND_COL, col, VAL_W'(column_count[col]), 1'b1);
        CMD_PIXEL: begin
          w = eff_dim(width_reg, DEF_MAX_WIDTH);
          h = eff_dim(height_reg, DEF_MAX_HEIGHT);
          if ((pix & LIT_MASK) != '0) begin
            q = (cur_y >= center_y_reg ? 2 : 0) + (cur_x >= center_x_reg ? 1 : 0);
            if (column_count[cur_x] != '1) column_count[cur_x]++;
            if (quad_total[q] != '1) quad_total[q]++;
            if (row_count != '1) row_count++;
          end
          if (cur_x + 1 >= w) begin
            last_row = (cur_y + 1 >= h);
            add_count(KIND_ROW, IDX_W'(cur_y), VAL_W'(row_count), !last_row);
            row_count = '0;
            cur_x     = 0;
            if (last_row) begin
              for (int k = 0; k < NQUAD; k++)
                add_count(KIND_QUAD, IDX_W'(k), quad_total[k], k == NQUAD - 1);
              cur_y = 0;
              frames_seen++;
            end else begin
              cur_y++;
            end
          end else begin
            cur_x++;
          end
        end
        default: ;
      endcase
    endfunction

    function void match_result(count_result_t got);
      count_result_t want;
      results_seen++;
      if (expected_counts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %s", $time, describe(got));
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch expected %s, actual %s",
                   $time, describe(want), describe(got));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata     = '0;
  logic [1:0]          s_tuser     = '0;
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [31:0]         m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IW-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i  = '0;

  bit                  calm         = 1'b0;
  bit                  hold_off_req = 1'b0;
  int                  items_sent   = 0;
  int                  settings_used = 0;
  int                  idle_cycles  = 0;
  projection_scoreboard sb = new();

  pixel_density_projection dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The scoreboard learns of each input at the edge of its transfer.
  task automatic send_item(cmd_t cmd, logic [PIX_W-1:0] pix, logic [IDX_W-1:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, col, pix};
    do @(posedge clk_i); while (!s_tready);
    sb.take_input(cmd, pix, col);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.expected_counts.size() != 0) @(posedge clk_i);
    // Pixels that end no row leave no trace to wait for, so let the pipeline settle.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned cx, int unsigned cy);
    wait_drain();
    write_reg(REG_FRAME_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    write_reg(REG_CENTER_X, CFG_W'(cx));
    write_reg(REG_CENTER_Y, CFG_W'(cy));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_tready <= 1'b1;
        repeat (calm ? 16 : $urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_tvalid && m_tready)
      sb.match_result({kind_t'(m_tuser), m_tdata[IDX_W-1:0],
                       m_tdata[IDX_W+VAL_W-1:IDX_W], m_tlast});
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still expected",
               $time, idle_cycles, sb.expected_counts.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [PIX_W-1:0] row_pix[12];
    int unsigned      w, h, n, lit_pct, r;
    int               phase, base;
    logic [PIX_W-1:0] pix;

    row_pix = '{8'h00, 8'h07, 8'h08, 8'hff,
                8'h80, 8'hf8, 8'h00, 8'h10,
                8'h01, 8'h20, 8'h40, 8'hff};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: a 640-wide frame, so two pixels end no row.
    send_item(CMD_PIXEL, 8'hff, 10'h000);
    send_item(CMD_PIXEL, 8'h00, 10'h3ff);
    send_item(CMD_READ, 8'h00, 10'd0);

    // Small frame whose second row is the center row.
    configure(4, 3, 2, 1);
    send_item(CMD_CLEAR, 8'h00, 10'h000);
    foreach (row_pix[i]) send_item(CMD_PIXEL, row_pix[i], 10'h155);
    send_item(CMD_READ, 8'hff, 10'd0);
    send_item(CMD_READ, 8'h00, 10'd3);
    send_item(CMD_READ, 8'h00, 10'd1023);
    send_item(CMD_READ, 8'h00, 10'd512);
    send_item(CMD_UNUSED, 8'hff, 10'h3ff);
    // Past the frame end the cursor wraps and counting carries on.
    send_item(CMD_PIXEL, 8'hff, 10'h3ff);
    send_item(CMD_PIXEL, 8'h08, 10'h2aa);
    send_item(CMD_READ, 8'h00, 10'd0);

    // Zero sizes act as one pixel, so every pixel closes a frame.
    configure(0, 0, 0, 0);
    send_item(CMD_CLEAR, 8'h00, 10'h000);
    repeat (4) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));
    configure(0, 0, 2047, 2047);
    // The receiver holds off while frame ends pile up, so the result queue fills.
    hold_off_req = 1'b1;
    wait (!hold_off_req);
    repeat (8) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));

    // Oversized registers clamp; then the width shrinks in the middle of a row.
    configure(2047, 2047, 5, 3);
    send_item(CMD_CLEAR, 8'h00, 10'h000);
    repeat (40) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));
    configure(3, 2, 1, 1);
    repeat (9) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));
    configure(3, 1, 1024, 0);
    repeat (5) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));

    // Random frames, mostly well formed with some stray commands mixed in.
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      configure(w, h, $urandom_range(0, w + 1), $urandom_range(0, h + 1));
      calm    = ($urandom_range(0, 3) == 0);
      lit_pct = $urandom_range(10, 90);
      if (phase == 1) hold_off_req = 1'b1;
      if ($urandom_range(0, 3) != 0) send_item(CMD_CLEAR, 8'($urandom), 10'($urandom));
      n = w * h * $urandom_range(1, 2) + $urandom_range(0, 2);
      repeat (n) begin
        if (items_sent - base >= RANDOM_ITEMS) break;
        r = $urandom_range(0, 99);
        if (r < 3)
          send_item(CMD_UNUSED, 8'($urandom), 10'($urandom));
        else if (r < 5)
          send_item(CMD_CLEAR, 8'($urandom), 10'($urandom));
        else if (r < 12)
          send_item(CMD_READ, 8'($urandom), 10'($urandom));
        else begin
          if ($urandom_range(0, 99) < lit_pct) pix = 8'($urandom_range(8, 255));
          else if ($urandom_range(0, 1) == 0) pix = 8'($urandom_range(0, 7));
          else pix = 8'($urandom);
          send_item(CMD_PIXEL, pix, 10'($urandom));
        end
      end
      repeat ($urandom_range(1, 3))
        send_item(CMD_READ, 8'($urandom), 10'($urandom_range(0, w + 2)));
      phase++;
    end
    calm = 1'b0;

    wait_drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d input items, %0d results and %0d frame ends over %0d register settings.",
             items_sent, sb.results_seen, sb.frames_seen, settings_used);
    $display("Sizes ran from zero to clamped frames, with a long output stall on a full queue.");
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* pixel_density_projection.f */
src/pdp_pkg.sv
src/pdp_col_store.sv
src/pdp_res_queue.sv
src/pixel_density_projection.sv
sim/pixel_density_projection_tb.sv
